/* hdl/afc_pkg.sv */
`default_nettype none

package afc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    // Q1.15 * Q16.16 products and the Q.31 sum of three of them less the offset
    localparam int PROD_W = 48;
    localparam int ACC_W  = 50;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    localparam logic [1:0] V_INSIDE  = 2'd0;
    localparam logic [1:0] V_ISECT   = 2'd1;
    localparam logic [1:0] V_OUTSIDE = 2'd2;

    // phases of one plane: three near-corner products, then three far-corner products
    localparam logic [2:0] PH_NEAR_X   = 3'd0;
    localparam logic [2:0] PH_NEAR_Y   = 3'd1;
    localparam logic [2:0] PH_NEAR_Z   = 3'd2;
    localparam logic [2:0] PH_NEAR_CHK = 3'd3;
    localparam logic [2:0] PH_FAR_Y    = 3'd4;
    localparam logic [2:0] PH_FAR_Z    = 3'd5;
    localparam logic [2:0] PH_FAR_CHK  = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] off;
        logic [2:0]         mask;
    } plane_t;

    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/afc_planes.sv */
`default_nettype none

module afc_planes (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [afc_pkg::PIDX_W-1:0] wr_idx,
    input  wire logic signed [15:0]         wr_nx,
    input  wire logic signed [15:0]         wr_ny,
    input  wire logic signed [15:0]         wr_nz,
    input  wire logic signed [31:0]         wr_off,
    input  wire logic [afc_pkg::PIDX_W-1:0] rd_idx,
    output afc_pkg::plane_t                 rd_plane
);
    import afc_pkg::*;

    plane_t plane_reg [NUM_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            plane_reg[wr_idx].nx   <= wr_nx;
            plane_reg[wr_idx].ny   <= wr_ny;
            plane_reg[wr_idx].nz   <= wr_nz;
            plane_reg[wr_idx].off  <= wr_off;
            // near corner takes max on axes with a negative normal component
            plane_reg[wr_idx].mask <= {wr_nz[15], wr_ny[15], wr_nx[15]};
        end
    end

    assign rd_plane = plane_reg[rd_idx];

endmodule

`default_nettype wire

/* hdl/afc_mac.sv */
`default_nettype none

module afc_mac (
    input  wire logic                clk,
    input  wire afc_pkg::mac_ctl_t   ctl,
    input  wire logic signed [15:0]  coef,
    input  wire logic signed [31:0]  coord,
    input  wire logic signed [31:0]  off,
    output logic                     sum_pos
);
    import afc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  off_q31;
    logic signed [ACC_W-1:0]  sum;

    assign off_q31 = {{(ACC_W-47){off[31]}}, off, 15'b0};
    assign sum     = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_pos = !sum[ACC_W-1] && (sum != '0);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = -off_q31;
        end
        else if (ctl.accum)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(coef * coord);
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

/* hdl/aabb_frustum_cull_top.sv */
// Load word: accepted while idle, no result.
// Test word: one shared multiply-accumulate unit walks the planes in phases
// (3 near-corner products, 3 far-corner products, checks folded in); an outside
// plane ends the walk at its near-corner check. The verdict is registered after the walk.
// Not ready for a new word while walking or stalled.
// Reset: all planes cleared to zero normal and offset, output empty, sequencer idle.
`default_nettype none

module aabb_frustum_cull_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [2:0]         plane_index,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire logic signed [15:0] normal_z,
    input  wire logic signed [31:0] plane_offset,
    input  wire logic signed [31:0] box_min_x,
    input  wire logic signed [31:0] box_min_y,
    input  wire logic signed [31:0] box_min_z,
    input  wire logic signed [31:0] box_max_x,
    input  wire logic signed [31:0] box_max_y,
    input  wire logic signed [31:0] box_max_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              verdict
);
    import afc_pkg::*;

    state_t state_reg, state_next;
    logic [PIDX_W-1:0] plane_reg, plane_next;
    logic [2:0]        phase_reg, phase_next;
    logic              isect_reg, isect_next;
    logic [1:0]        res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        verdict_reg, verdict_next;

    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];

    logic              accept;
    logic              load_wr;
    logic              last_plane;
    logic              out_free;
    logic              sum_pos;
    logic [1:0]        axis;
    logic              far_side;
    logic              use_hi;
    logic signed [15:0] coef;
    logic signed [31:0] coord;
    mac_ctl_t          mac_ctl;
    plane_t            plane;

    assign accept     = in_valid && in_ready;
    assign load_wr    = accept && (action == ACT_LOAD) && (int'(plane_index) < NUM_PLANES);
    assign last_plane = (plane_reg == PIDX_W'(NUM_PLANES - 1));
    assign out_free   = !out_valid_reg || out_ready;

    afc_planes u_planes (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_wr),
        .wr_idx   (PIDX_W'(plane_index)),
        .wr_nx    (normal_x),
        .wr_ny    (normal_y),
        .wr_nz    (normal_z),
        .wr_off   (plane_offset),
        .rd_idx   (plane_reg),
        .rd_plane (plane)
    );

    // operand select for the current phase
    always_comb
    begin
        case (phase_reg)
            PH_NEAR_X:   axis = 2'd0;
            PH_NEAR_Y:   axis = 2'd1;
            PH_NEAR_Z:   axis = 2'd2;
            PH_NEAR_CHK: axis = 2'd0;
            PH_FAR_Y:    axis = 2'd1;
            PH_FAR_Z:    axis = 2'd2;
            default:     axis = 2'd0;
        endcase
        far_side = (phase_reg >= PH_NEAR_CHK);
        use_hi   = plane.mask[axis] ^ far_side;
        case (axis)
            2'd0:    coef = plane.nx;
            2'd1:    coef = plane.ny;
            default: coef = plane.nz;
        endcase
        coord = use_hi ? hi_reg[axis] : lo_reg[axis];
    end

    afc_mac u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .coef    (coef),
        .coord   (coord),
        .off     (plane.off),
        .sum_pos (sum_pos)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_TEST))
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if ((phase_reg == PH_NEAR_CHK) && sum_pos)
                begin
                    state_next = S_DONE;
                end
                else if ((phase_reg == PH_FAR_CHK) && last_plane)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_ready       = 1'b0;
        mac_ctl        = '0;
        plane_next     = plane_reg;
        phase_next     = phase_reg;
        isect_next     = isect_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                plane_next = '0;
                phase_next = PH_NEAR_X;
                isect_next = 1'b0;
            end
            S_RUN:
            begin
                case (phase_reg)
                    PH_NEAR_X:
                    begin
                        mac_ctl.load = 1'b1;
                        phase_next   = PH_NEAR_Y;
                    end
                    PH_NEAR_CHK:
                    begin
                        mac_ctl.load = 1'b1;
                        phase_next   = PH_FAR_Y;
                        if (sum_pos)
                        begin
                            res_next = V_OUTSIDE;
                        end
                    end
                    PH_FAR_CHK:
                    begin
                        phase_next = PH_NEAR_X;
                        plane_next = plane_reg + 1'b1;
                        isect_next = isect_reg || sum_pos;
                        res_next   = (isect_reg || sum_pos) ? V_ISECT : V_INSIDE;
                    end
                    default:
                    begin
                        mac_ctl.accum = 1'b1;
                        phase_next    = phase_reg + 3'd1;
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plane_reg     <= '0;
            phase_reg     <= PH_NEAR_X;
            isect_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            phase_reg     <= phase_next;
            isect_reg     <= isect_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        verdict_reg <= verdict_next;
        if (accept && (action == ACT_TEST))
        begin
            lo_reg[0] <= box_min_x;
            lo_reg[1] <= box_min_y;
            lo_reg[2] <= box_min_z;
            hi_reg[0] <= box_max_x;
            hi_reg[1] <= box_max_y;
            hi_reg[2] <= box_max_z;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

`default_nettype wire

/* tb/tb_aabb_frustum_cull_top.sv */
`default_nettype none

module tb_aabb_frustum_cull_top;
    import afc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 64;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic        act;
        logic [2:0]  idx;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [31:0] off;
        logic [31:0] lox;
        logic [31:0] loy;
        logic [31:0] loz;
        logic [31:0] hix;
        logic [31:0] hiy;
        logic [31:0] hiz;
    } cull_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [2:0]         plane_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         verdict;

    // predictor copy of the plane store
    logic [15:0] plane_nx [NUM_PLANES];
    logic [15:0] plane_ny [NUM_PLANES];
    logic [15:0] plane_nz [NUM_PLANES];
    logic [31:0] plane_off [NUM_PLANES];
    logic [2:0]  plane_near_mask [NUM_PLANES];

    logic [1:0] expected_verdicts [$];
    int         mismatch_count;
    int         cycle_count;
    bit         idle_on;
    int         hold_req;
    int         hold_left;
    int         ready_gap;

    aabb_frustum_cull_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .plane_index  (plane_index),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .verdict      (verdict)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // signed distance in Q.31: n.p - (offset << 15)
    function automatic longint plane_dist(input int p, input longint px, input longint py,
                                          input longint pz);
        return longint'($signed(plane_nx[p])) * px + longint'($signed(plane_ny[p])) * py
             + longint'($signed(plane_nz[p])) * pz - longint'($signed(plane_off[p])) * 32768;
    endfunction

    function automatic logic [1:0] classify_box(input cull_word_t w);
        longint lo [3];
        longint hi [3];
        longint nr [3];
        longint fr [3];
        bit     isect;
        lo[0] = longint'($signed(w.lox));
        lo[1] = longint'($signed(w.loy));
        lo[2] = longint'($signed(w.loz));
        hi[0] = longint'($signed(w.hix));
        hi[1] = longint'($signed(w.hiy));
        hi[2] = longint'($signed(w.hiz));
        isect = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nr[a] = plane_near_mask[p][a] ? hi[a] : lo[a];
                fr[a] = plane_near_mask[p][a] ? lo[a] : hi[a];
            end
            if (plane_dist(p, nr[0], nr[1], nr[2]) > 0)
                return V_OUTSIDE;
            if (plane_dist(p, fr[0], fr[1], fr[2]) > 0)
                isect = 1'b1;
        end
        return isect ? V_ISECT : V_INSIDE;
    endfunction

    // ------------------------------------------------------------------
    // word builders and random shaping
    // ------------------------------------------------------------------

    function automatic cull_word_t make_plane(input int idx, input int nx, input int ny,
                                              input int nz, input int off);
        cull_word_t w;
        w     = '0;
        w.act = ACT_LOAD;
        w.idx = idx[2:0];
        w.nx  = nx[15:0];
        w.ny  = ny[15:0];
        w.nz  = nz[15:0];
        w.off = off;
        return w;
    endfunction

    function automatic cull_word_t make_box(input int lx, input int ly, input int lz,
                                            input int hx, input int hy, input int hz);
        cull_word_t w;
        w     = '0;
        w.act = ACT_TEST;
        w.lox = lx;
        w.loy = ly;
        w.loz = lz;
        w.hix = hx;
        w.hiy = hy;
        w.hiz = hz;
        return w;
    endfunction

    function automatic int span_pick();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 1 << 20);
            1:       return $urandom_range(0, 1 << 26);
            default: return $urandom_range(0, 1 << 30);
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cull_word_t random_word();
        cull_word_t w;
        int         sel;
        int         idx;
        int         c;
        int         h;
        int         lo [3];
        int         hi [3];
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            // noise: every field fully random
            w.act = 1'($urandom_range(0, 1));
            w.idx = 3'($urandom_range(0, 7));
            w.nx  = 16'($urandom);
            w.ny  = 16'($urandom);
            w.nz  = 16'($urandom);
            w.off = $urandom;
            w.lox = $urandom;
            w.loy = $urandom;
            w.loz = $urandom;
            w.hix = $urandom;
            w.hiy = $urandom;
            w.hiz = $urandom;
        end
        else if (sel < 30)
        begin
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5);
            w = make_plane(idx, $urandom, $urandom, $urandom,
                           $urandom_range(1 << 21, 1 << 25));
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                c = span_pick();
                if ($urandom_range(0, 1))
                    c = -c;
                h = span_pick() >> 1;
                lo[a] = c - h;
                hi[a] = c + h;
                // inverted box on this axis now and then
                if ($urandom_range(0, 19) == 0)
                begin
                    lo[a] = c + h;
                    hi[a] = c - h;
                end
            end
            w = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // driver, receiver, checker
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input cull_word_t w);
        int gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action       <= w.act;
        plane_index  <= w.idx;
        normal_x     <= w.nx;
        normal_y     <= w.ny;
        normal_z     <= w.nz;
        plane_offset <= w.off;
        box_min_x    <= w.lox;
        box_min_y    <= w.loy;
        box_min_z    <= w.loz;
        box_max_x    <= w.hix;
        box_max_y    <= w.hiy;
        box_max_z    <= w.hiz;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (w.act == ACT_TEST)
            expected_verdicts.push_back(classify_box(w));
        else if (w.idx < NUM_PLANES)
        begin
            plane_nx[w.idx]        = w.nx;
            plane_ny[w.idx]        = w.ny;
            plane_nz[w.idx]        = w.nz;
            plane_off[w.idx]       = w.off;
            plane_near_mask[w.idx] = {w.nz[15], w.ny[15], w.nx[15]};
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (ready_gap != 0)
        begin
            ready_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            ready_gap = idle_gap();
        end
    end

    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected verdict", verdict, 2'bxx);
            else if (verdict !== expected_verdicts[0])
                report_mismatch("verdict", verdict, expected_verdicts.pop_front());
            else
                void'(expected_verdicts.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fresh planes are all zero: nothing is ever culled or cut
    task automatic test_unloaded_planes();
        send_word(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_word(make_box(32'h7fff_ffff, 5, 32'h8000_0000, 32'h8000_0000, -5, 32'h7fff_ffff));
    endtask

    task automatic test_extreme_planes();
        send_word(make_plane(0, -32768, -32768, -32768, 32'h8000_0000));
        send_word(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_word(make_plane(1, 32767, 32767, 32767, 32'h7fff_ffff));
        send_word(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_word(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    endtask

    // loads to plane slots past the end must leave the store alone
    task automatic test_ignored_index();
        send_word(make_plane(6, 32767, 0, 0, 32'h8000_0000));
        send_word(make_plane(7, 0, -32768, 0, 32'h8000_0000));
        send_word(make_box(-100, -100, -100, 100, 100, 100));
    endtask

    // axis-aligned unit cube; zero normal components pick the min corner
    task automatic test_unit_cube();
        send_word(make_plane(0, 32767, 0, 0, 32'h0001_0000));
        send_word(make_plane(1, -32768, 0, 0, 32'h0001_0000));
        send_word(make_plane(2, 0, 32767, 0, 32'h0001_0000));
        send_word(make_plane(3, 0, -32768, 0, 32'h0001_0000));
        send_word(make_plane(4, 0, 0, 32767, 32'h0001_0000));
        send_word(make_plane(5, 0, 0, -32768, 32'h0001_0000));
        send_word(make_box(-32768, -32768, -32768, 32768, 32768, 32768));
        send_word(make_box(32768, -32768, -32768, 32'h0002_0000, 32768, 32768));
        send_word(make_box(32'h0002_0000, 0, 0, 32'h0003_0000, 0, 0));
        send_word(make_box(32768, 32768, 32768, -32768, -32768, -32768));
        send_word(make_box(0, 0, 0, 0, 0, 0));
        send_word(make_box(0, 32'h0005_0000, 0, 0, -32'sh0005_0000, 0));
    endtask

    task automatic load_random_frustum();
        for (int p = 0; p < NUM_PLANES; p++)
            send_word(make_plane(p, $urandom, $urandom, $urandom,
                                 $urandom_range(1 << 21, 1 << 25)));
    endtask

    task automatic test_random_scenes(input int n_words);
        cull_word_t w;
        int         counted;
        counted = 0;
        while (counted < n_words)
        begin
            if (counted % 120 == 0)
            begin
                load_random_frustum();
                counted += NUM_PLANES;
            end
            if (counted % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            w = random_word();
            send_word(w);
            if (!(w.act == ACT_LOAD && w.idx >= NUM_PLANES))
                counted++;
        end
        idle_on = 1'b1;
    endtask

    // receiver stalls for a long stretch while tests keep coming
    task automatic test_output_stall();
        idle_on  = 1'b0;
        hold_req = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            send_word(random_word());
        idle_on = 1'b1;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        action         = ACT_LOAD;
        plane_index    = '0;
        normal_x       = '0;
        normal_y       = '0;
        normal_z       = '0;
        plane_offset   = '0;
        box_min_x      = '0;
        box_min_y      = '0;
        box_min_z      = '0;
        box_max_x      = '0;
        box_max_y      = '0;
        box_max_z      = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        hold_req       = 0;
        hold_left      = 0;
        ready_gap      = 0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_nx[p]        = '0;
            plane_ny[p]        = '0;
            plane_nz[p]        = '0;
            plane_off[p]       = '0;
            plane_near_mask[p] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_unloaded_planes();
        test_extreme_planes();
        test_ignored_index();
        test_unit_cube();
        test_random_scenes(300);
        test_output_stall();
        test_random_scenes(300);
        wait_drained();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
